FILE: hw/rtl/lscd_pkg.sv
// ----------------------------------------------------------------------------
// lscd_pkg
// Shared types and constants of the line sensor calibrate/digitize block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lscd_pkg;

  localparam int NumChannels = 8;
  localparam int SampleBits  = 10;

  localparam int ChanFieldBits = 3;
  localparam int SampleFieldBits = 10;
  localparam int SpanBits = 10;
  localparam int ThrFieldBits = 10;
  localparam int CountBits = 4;

  localparam int ChanIdxBits = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int CmpBits = (SampleBits > SpanBits) ? SampleBits : SpanBits;

  localparam logic [SpanBits-1:0]  MinSpanReset = SpanBits'(200);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] CountFull = CountBits'(NumChannels);

  localparam logic CmdCalibrate = 1'b0;
  localparam logic CmdDigitize  = 1'b1;

  localparam logic [0:0] RegMinSpan = 1'b0;

  typedef struct packed {
    logic                       cmd;
    logic [ChanFieldBits-1:0]   channel;
    logic [SampleFieldBits-1:0] sample;
    logic                       sweep_end;
  } req_t;

  typedef struct packed {
    logic                    line_bit;
    logic                    channel_ready;
    logic                    all_ready;
    logic [ThrFieldBits-1:0] level_threshold;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                   cmd;
    logic                   chan_ok;
    logic [ChanIdxBits-1:0] idx;
    logic [SampleBits-1:0]  sample;
    logic                   sweep_end;
  } op_t;

  function automatic logic [SampleBits-1:0] take_sample(
    input logic [SampleFieldBits-1:0] raw
  );
    logic [CmpBits+SampleFieldBits-1:0] ext;
    ext = {{CmpBits{1'b0}}, raw};
    return ext[SampleBits-1:0];
  endfunction

endpackage

FILE: hw/rtl/line_sensor_calibrate_digitize.sv
// ----------------------------------------------------------------------------
// line_sensor_calibrate_digitize
// Line sensor min/max calibration and threshold digitizer with APB register.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high and returns one result
// per request, in order. A request passes the intake register, a two-entry
// queue and the per-channel read-modify-write stage, which loads the result
// register; the channel state update is done as the request leaves the queue,
// so a new request is taken every cycle while results are taken. A full result
// register that is not taken backs up into the queue and then into req_ready.
// min_span resets to 200 and is written at APB addresses with paddr[2] clear.
`timescale 1ns / 1ps

module line_sensor_calibrate_digitize (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lscd_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output lscd_pkg::res_t res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import lscd_pkg::*;

  logic [SpanBits-1:0] min_span;
  logic                f_valid, f_ready;
  op_t                 f_op;
  logic                q_valid, q_ready;
  op_t                 q_op;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMinSpan) ? {{(32-SpanBits){1'b0}}, min_span} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_span <= MinSpanReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegMinSpan)) begin
      min_span <= pwdata[SpanBits-1:0];
    end
  end

  lscd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  lscd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  lscd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .min_span  (min_span),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

FILE: hw/rtl/lscd_front.sv
// ----------------------------------------------------------------------------
// lscd_front
// Request intake: registers each request and classifies channel and sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lscd_pkg::req_t req,
  output logic          op_valid,
  input  logic          op_ready,
  output lscd_pkg::op_t op
);
  import lscd_pkg::*;

  logic hold_valid;
  op_t  hold;
  op_t  cls;

  always_comb begin
    cls.cmd       = req.cmd;
    cls.chan_ok   = ({29'd0, req.channel} < 32'(NumChannels));
    cls.idx       = ChanIdxBits'(req.channel);
    cls.sample    = take_sample(req.sample);
    cls.sweep_end = req.sweep_end;
  end

  assign req_ready = !hold_valid || op_ready;
  assign op_valid  = hold_valid;
  assign op        = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      hold <= cls;
    end
  end

endmodule

FILE: hw/rtl/lscd_queue.sv
// ----------------------------------------------------------------------------
// lscd_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  lscd_pkg::op_t wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output lscd_pkg::op_t rd_op
);
  import lscd_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_op    = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

endmodule

FILE: hw/rtl/lscd_back.sv
// ----------------------------------------------------------------------------
// lscd_back
// Per-channel min/max tracking, threshold update, digitize and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lscd_pkg::SpanBits-1:0] min_span,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  lscd_pkg::op_t                 op,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lscd_pkg::res_t                res
);
  import lscd_pkg::*;

  logic [SampleBits-1:0] lightest_level    [NumChannels];
  logic [SampleBits-1:0] darkest_level     [NumChannels];
  logic [SampleBits-1:0] channel_threshold [NumChannels];
  logic [CountBits-1:0]  ready_count;

  logic                  fire;
  logic                  cal;
  logic                  act;
  logic [SampleBits-1:0] lo_cur, hi_cur, thr_cur;
  logic [SampleBits-1:0] lo_new, hi_new, thr_new;
  logic [SampleBits-1:0] span;
  logic [SampleBits:0]   sum;
  logic                  span_ok;
  logic                  hit;
  logic [CountBits-1:0]  count_after;
  logic [CountBits-1:0]  ready_count_next;
  res_t                  res_next;

  assign op_ready = !res_valid || res_ready;
  assign fire     = op_valid && op_ready;
  assign cal      = (op.cmd == CmdCalibrate);
  assign act      = fire && op.chan_ok;

  always_comb begin
    lo_cur  = lightest_level[op.idx];
    hi_cur  = darkest_level[op.idx];
    thr_cur = channel_threshold[op.idx];
    lo_new  = (op.sample < lo_cur) ? op.sample : lo_cur;
    hi_new  = (op.sample > hi_cur) ? op.sample : hi_cur;
    span    = hi_new - lo_new;
    sum     = {1'b0, hi_new} + {1'b0, lo_new};
    span_ok = (hi_new > lo_new) && (CmpBits'(span) > CmpBits'(min_span));
    hit     = cal && op.chan_ok && span_ok;
    thr_new = hit ? sum[SampleBits:1] : thr_cur;

    count_after = ready_count;
    if (hit && (ready_count < CountMax)) begin
      count_after = ready_count + CountBits'(1);
    end
    ready_count_next = (cal && op.sweep_end) ? '0 : count_after;

    res_next.line_bit        = !cal && op.chan_ok && (op.sample > thr_cur);
    res_next.channel_ready   = hit;
    res_next.all_ready       = cal && op.sweep_end && (count_after == CountFull);
    res_next.level_threshold = op.chan_ok
                               ? ThrFieldBits'({{CmpBits{1'b0}}, thr_new}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumChannels; k++) begin
        lightest_level[k]    <= {SampleBits{1'b1}};
        darkest_level[k]     <= '0;
        channel_threshold[k] <= SampleBits'(1) << (SampleBits - 1);
      end
      ready_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (op_ready) res_valid <= op_valid;
      if (fire) ready_count <= ready_count_next;
      if (act && cal) begin
        lightest_level[op.idx]    <= lo_new;
        darkest_level[op.idx]     <= hi_new;
        channel_threshold[op.idx] <= thr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule
